### rtl/core/tlv_chunk_framer_resync_defines.svh
// Assertion macros used by the checker of the chunk framer.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef TLV_CHUNK_FRAMER_RESYNC_DEFINES_SVH
`define TLV_CHUNK_FRAMER_RESYNC_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TCFR_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define TCFR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/tcfr_pkg.sv
package tcfr_pkg;

    localparam int BUF_DEPTH_DEF = 4096;

    localparam logic [7:0] START_OFFSET_RST = 8'd8;

    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_FETCH  = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    localparam logic [7:0] LEN_ESCAPE = 8'd255;
    localparam logic [2:0] HDR_SHORT  = 3'd2;
    localparam logic [2:0] HDR_LONG   = 3'd6;

    // Header byte indexes as seen by the fetch sequencer (capture side).
    localparam logic [2:0] HB_ID   = 3'd1;
    localparam logic [2:0] HB_LEN  = 3'd2;
    localparam logic [2:0] HB_EXT0 = 3'd3;
    localparam logic [2:0] HB_EXT1 = 3'd4;
    localparam logic [2:0] HB_EXT2 = 3'd5;
    localparam logic [2:0] HB_EXT3 = 3'd6;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HDR,
        ST_EVAL
    } state_t;

    typedef struct packed {
        logic       has;
        logic [7:0] len;
    } fixlen_t;

    typedef struct packed {
        logic len_ok;
        logic fits;
    } verdict_t;

    // Ids that only ever carry one value length.
    function automatic fixlen_t fixed_length(input logic [7:0] id);
        fixlen_t f;
        f.has = 1'b1;
        case (id)
            8'h08:   f.len = 8'd6;
            8'h0B:   f.len = 8'd20;
            8'h0E:   f.len = 8'd6;
            8'h14:   f.len = 8'd7;
            8'h16:   f.len = 8'd195;
            8'h17:   f.len = 8'd14;
            default:
            begin
                f.has = 1'b0;
                f.len = 8'd0;
            end
        endcase
        return f;
    endfunction

endpackage

### rtl/core/tcfr_cmd_if.sv
interface tcfr_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] data_byte;

    modport source (output valid, command, data_byte, input ready);
    modport sink (input valid, command, data_byte, output ready);
endinterface

### rtl/core/tcfr_res_if.sv
interface tcfr_res_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [7:0]  tlv_id;
    logic [11:0] value_offset;
    logic [31:0] value_length;
    logic        extended_header;
    logic        overflowed;

    modport source (output valid, found, tlv_id, value_offset, value_length,
                    extended_header, overflowed, input ready);
    modport sink (input valid, found, tlv_id, value_offset, value_length,
                  extended_header, overflowed, output ready);
endinterface

### rtl/core/tcfr_hdr_check.sv
module tcfr_hdr_check #(
    parameter int PW = 13,
    parameter int CW = 13
) (
    input  logic [PW-1:0]     pos,
    input  logic [CW-1:0]     fill,
    input  logic [7:0]        id,
    input  logic [31:0]       len,
    input  logic              ext,
    output tcfr_pkg::verdict_t verdict,
    output logic [PW-1:0]     end_pos,
    output logic [11:0]       value_offset
);

    // The bounds sum is wide enough that it can never wrap.
    localparam int SW = ((PW > 32) ? PW : 32) + 2;
    localparam int OW = ((PW + 1) > 12) ? (PW + 1) : 12;

    tcfr_pkg::fixlen_t fl;
    logic [2:0]        hdr;
    logic [SW-1:0]     total;
    logic [OW-1:0]     voff;

    always_comb
    begin
        fl             = tcfr_pkg::fixed_length(id);
        hdr            = ext ? tcfr_pkg::HDR_LONG : tcfr_pkg::HDR_SHORT;
        total          = SW'(pos) + SW'(hdr) + SW'(len);
        voff           = OW'(pos) + OW'(hdr);
        verdict.len_ok = !fl.has || (len == {24'd0, fl.len});
        verdict.fits   = (total <= SW'(fill));
        end_pos        = total[PW-1:0];
        value_offset   = voff[11:0];
    end

endmodule

### rtl/core/tlv_chunk_framer_resync.sv
// TLV chunk framer with resynchronization. Append and clear items produce no
// result. A fetch item is scanned out of the byte store one candidate position
// at a time through its single read port, whose read data is registered: the
// header of each candidate (two bytes, or the extended six-byte header) is read
// and checked, an escape header that would overrun the fill is dropped before
// its extended length is read, and a final check reports that nothing is left.
// A fetch's total time therefore grows with the number of rejected positions
// between the read position and the next valid chunk. Results sit in an output
// register, so appends and clears continue while a result waits; a new fetch
// that completes while the previous result is still held waits for it to be
// taken. The store needs no clearing after reset; only its control state is reset.
module tlv_chunk_framer_resync #(
    parameter int BUF_DEPTH = tcfr_pkg::BUF_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [7:0]        cfg_wdata,
    tcfr_cmd_if.sink          cmd,
    tcfr_res_if.source        res
);

    localparam int AW = $clog2(BUF_DEPTH);
    localparam int CW = $clog2(BUF_DEPTH + 1);
    localparam int PW = (CW > 8) ? CW : 8;

    tcfr_pkg::state_t state_reg, state_next;

    logic [PW-1:0] pos_reg, pos_next;
    logic [PW-1:0] rdpos_reg, rdpos_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic          ovf_reg, ovf_next;
    logic [7:0]    start_reg;
    logic [2:0]    k_reg, k_next;
    logic [7:0]    id_reg, id_next;
    logic [31:0]   len_reg, len_next;
    logic          ext_reg, ext_next;

    logic          out_valid_reg, out_valid_next;
    logic          res_found_reg;
    logic [7:0]    res_id_reg;
    logic [11:0]   res_off_reg;
    logic [31:0]   res_len_reg;
    logic          res_ext_reg;
    logic          res_ovf_reg;

    logic          load_res;
    logic          load_found;

    logic [7:0]    mem [BUF_DEPTH];
    logic [7:0]    rdata_reg;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;

    logic [PW:0]   rd_sum;
    logic [PW:0]   pos_plus1;
    logic          short_fits;
    logic          long_fits;
    logic          slot_free;
    logic          accept_in;

    tcfr_pkg::verdict_t verdict;
    logic [PW-1:0]      end_pos;
    logic [11:0]        value_offset;

    tcfr_hdr_check #(
        .PW (PW),
        .CW (CW)
    ) u_hdr_check (
        .pos          (pos_reg),
        .fill         (fill_reg),
        .id           (id_reg),
        .len          (len_reg),
        .ext          (ext_reg),
        .verdict      (verdict),
        .end_pos      (end_pos),
        .value_offset (value_offset)
    );

    // Appends write during the accepting cycle; a fetch reads no earlier than the
    // cycle after, so the store never needs forwarding.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= cmd.data_byte;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_comb
    begin
        rd_sum     = {1'b0, pos_reg} + (PW + 1)'(k_reg);
        rd_addr    = rd_sum[AW-1:0];
        wr_addr    = fill_reg[AW-1:0];
        pos_plus1  = {1'b0, pos_reg} + (PW + 1)'(1);
        short_fits = ({1'b0, pos_reg} + (PW + 1)'(tcfr_pkg::HDR_SHORT)) <= (PW + 1)'(fill_reg);
        long_fits  = ({1'b0, pos_reg} + (PW + 1)'(tcfr_pkg::HDR_LONG)) <= (PW + 1)'(fill_reg);
        slot_free  = !out_valid_reg || res.ready;
        accept_in  = cmd.valid && cmd.ready;
    end

    always_comb
    begin
        cmd.ready  = (state_reg == tcfr_pkg::ST_IDLE);
        state_next = state_reg;
        pos_next   = pos_reg;
        rdpos_next = rdpos_reg;
        fill_next  = fill_reg;
        ovf_next   = ovf_reg;
        k_next     = k_reg;
        id_next    = id_reg;
        len_next   = len_reg;
        ext_next   = ext_reg;
        wr_en      = 1'b0;
        load_res   = 1'b0;
        load_found = 1'b0;

        unique case (state_reg)
            tcfr_pkg::ST_IDLE:
            begin
                if (accept_in)
                begin
                    case (cmd.command)
                        tcfr_pkg::CMD_APPEND:
                        begin
                            if (fill_reg < CW'(BUF_DEPTH))
                            begin
                                wr_en     = 1'b1;
                                fill_next = fill_reg + CW'(1);
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        tcfr_pkg::CMD_FETCH:
                        begin
                            pos_next   = rdpos_reg;
                            state_next = tcfr_pkg::ST_SCAN;
                        end
                        tcfr_pkg::CMD_CLEAR:
                        begin
                            fill_next  = '0;
                            rdpos_next = PW'(start_reg);
                            ovf_next   = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            tcfr_pkg::ST_SCAN:
            begin
                if (!short_fits)
                begin
                    if (slot_free)
                    begin
                        load_res   = 1'b1;
                        state_next = tcfr_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    k_next     = '0;
                    state_next = tcfr_pkg::ST_HDR;
                end
            end
            tcfr_pkg::ST_HDR:
            begin
                // One header byte address goes out per cycle; the byte asked for
                // in the previous cycle is captured.
                k_next = k_reg + 3'd1;
                case (k_reg)
                    tcfr_pkg::HB_ID:   id_next = rdata_reg;
                    tcfr_pkg::HB_LEN:
                    begin
                        if (rdata_reg != tcfr_pkg::LEN_ESCAPE)
                        begin
                            len_next   = {24'd0, rdata_reg};
                            ext_next   = 1'b0;
                            state_next = tcfr_pkg::ST_EVAL;
                        end
                        else if (!long_fits)
                        begin
                            pos_next   = pos_plus1[PW-1:0];
                            state_next = tcfr_pkg::ST_SCAN;
                        end
                    end
                    tcfr_pkg::HB_EXT0: len_next[7:0]   = rdata_reg;
                    tcfr_pkg::HB_EXT1: len_next[15:8]  = rdata_reg;
                    tcfr_pkg::HB_EXT2: len_next[23:16] = rdata_reg;
                    tcfr_pkg::HB_EXT3:
                    begin
                        len_next[31:24] = rdata_reg;
                        ext_next        = 1'b1;
                        state_next      = tcfr_pkg::ST_EVAL;
                    end
                    default:
                    begin
                    end
                endcase
            end
            tcfr_pkg::ST_EVAL:
            begin
                if (verdict.len_ok && verdict.fits)
                begin
                    if (slot_free)
                    begin
                        load_res   = 1'b1;
                        load_found = 1'b1;
                        rdpos_next = end_pos;
                        state_next = tcfr_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    pos_next   = pos_plus1[PW-1:0];
                    state_next = tcfr_pkg::ST_SCAN;
                end
            end
            default:
            begin
                state_next = tcfr_pkg::ST_IDLE;
            end
        endcase

        if (load_res)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tcfr_pkg::ST_IDLE;
            rdpos_reg     <= PW'(tcfr_pkg::START_OFFSET_RST);
            fill_reg      <= '0;
            ovf_reg       <= 1'b0;
            start_reg     <= tcfr_pkg::START_OFFSET_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rdpos_reg     <= rdpos_next;
            fill_reg      <= fill_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                start_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        k_reg   <= k_next;
        id_reg  <= id_next;
        len_reg <= len_next;
        ext_reg <= ext_next;
        if (load_res)
        begin
            res_found_reg <= load_found;
            res_id_reg    <= load_found ? id_reg : 8'd0;
            res_off_reg   <= load_found ? value_offset : 12'd0;
            res_len_reg   <= load_found ? len_reg : 32'd0;
            res_ext_reg   <= load_found && ext_reg;
            res_ovf_reg   <= ovf_reg;
        end
    end

    assign res.valid           = out_valid_reg;
    assign res.found           = res_found_reg;
    assign res.tlv_id          = res_id_reg;
    assign res.value_offset    = res_off_reg;
    assign res.value_length    = res_len_reg;
    assign res.extended_header = res_ext_reg;
    assign res.overflowed      = res_ovf_reg;

endmodule

### rtl/core/tcfr_checker.sv
`include "tlv_chunk_framer_resync_defines.svh"

module tcfr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_ready,
    input logic        found,
    input logic [7:0]  tlv_id,
    input logic [11:0] value_offset,
    input logic [31:0] value_length,
    input logic        extended_header,
    input logic        overflowed
);

    logic [54:0] res_payload;

    assign res_payload = {found, tlv_id, value_offset, value_length,
                          extended_header, overflowed};

    `TCFR_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_payload), "result changed while stalled")

    `TCFR_ASSERT_IMPL(a_notfound_zero, res_valid && !found, tlv_id == 8'd0 && value_offset == 12'd0 && value_length == 32'd0 && !extended_header, "not-found result carries chunk fields")

    `TCFR_ASSERT_IMPL(a_short_len, res_valid && found && !extended_header, value_length < 32'd255, "short header with escape length")

    `TCFR_ASSERT_IMPL(a_fixed_len, res_valid && found, (tlv_id != 8'h16 || value_length == 32'd195) && (tlv_id != 8'h0B || value_length == 32'd20), "fixed-length id with wrong length")

endmodule

bind tlv_chunk_framer_resync tcfr_checker u_tcfr_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .res_valid       (res.valid),
    .res_ready       (res.ready),
    .found           (res.found),
    .tlv_id          (res.tlv_id),
    .value_offset    (res.value_offset),
    .value_length    (res.value_length),
    .extended_header (res.extended_header),
    .overflowed      (res.overflowed)
);

### tb/tlv_chunk_framer_resync_test.sv
`timescale 1ns / 1ps

module tlv_chunk_framer_resync_test;

    localparam int STORE_DEPTH = tcfr_pkg::BUF_DEPTH_DEF;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 20;
    localparam int WATCHDOG_LIMIT = 200000;

    typedef struct packed {
        logic        found;
        logic [7:0]  tlv_id;
        logic [11:0] value_offset;
        logic [31:0] value_length;
        logic        extended_header;
        logic        overflowed;
    } chunk_result_t;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] value;
    } command_item_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    logic [7:0] cfg_wdata;

    tcfr_cmd_if cmd ();
    tcfr_res_if res ();

    tlv_chunk_framer_resync uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .res       (res)
    );

    // Mirror of the block's state.
    logic [7:0]  mirror_bytes [0:STORE_DEPTH-1];
    int unsigned mirror_fill = 0;
    int unsigned mirror_rd = 32'(tcfr_pkg::START_OFFSET_RST);
    bit          mirror_ovf = 1'b0;
    logic [7:0]  mirror_start;

    command_item_t cmd_backlog[$];
    chunk_result_t chunks_expected[$];
    command_item_t next_item;
    chunk_result_t oldest_chunk;

    int  hold_off;
    int  stall_left;
    int  quiet_cycles;
    bit  steady_flow;
    logic [7:0] phase_start;
    int  queued_items;
    int  items_taken = 0;
    int  chunks_checked = 0;
    int  chunks_found = 0;
    int  chunks_extended = 0;
    int  error_count = 0;

    always #1 clk = ~clk;

    function automatic bit [8:0] pinned_length(input logic [7:0] id);
        case (id)
            8'h08:   pinned_length = {1'b1, 8'd6};
            8'h0B:   pinned_length = {1'b1, 8'd20};
            8'h0E:   pinned_length = {1'b1, 8'd6};
            8'h14:   pinned_length = {1'b1, 8'd7};
            8'h16:   pinned_length = {1'b1, 8'd195};
            8'h17:   pinned_length = {1'b1, 8'd14};
            default: pinned_length = 9'd0;
        endcase
    endfunction

    // Walks forward from the read position one byte at a time until a header
    // passes both the fixed-length and the bounds test.
    function automatic chunk_result_t scan_next_chunk();
        chunk_result_t    r;
        longint unsigned  pos;
        longint unsigned  fill;
        longint unsigned  len;
        longint unsigned  hdr;
        longint unsigned  offs;
        bit [8:0]         pin;
        bit               ok;
        r = '0;
        r.overflowed = mirror_ovf;
        pos = 64'(mirror_rd);
        fill = 64'(mirror_fill);
        while (!r.found && pos + tcfr_pkg::HDR_SHORT <= fill)
        begin
            ok = 1'b1;
            len = 64'(mirror_bytes[pos + 1]);
            hdr = 64'(tcfr_pkg::HDR_SHORT);
            if (len == tcfr_pkg::LEN_ESCAPE)
            begin
                if (pos + tcfr_pkg::HDR_LONG > fill)
                    ok = 1'b0;
                else
                begin
                    len = 64'({mirror_bytes[pos + 5], mirror_bytes[pos + 4],
                               mirror_bytes[pos + 3], mirror_bytes[pos + 2]});
                    hdr = 64'(tcfr_pkg::HDR_LONG);
                end
            end
            pin = pinned_length(mirror_bytes[pos]);
            if (ok && pin[8] && len != pin[7:0])
                ok = 1'b0;
            if (ok && pos + hdr + len > fill)
                ok = 1'b0;
            if (ok)
            begin
                offs = pos + hdr;
                r.found = 1'b1;
                r.tlv_id = mirror_bytes[pos];
                r.value_offset = offs[11:0];
                r.value_length = len[31:0];
                r.extended_header = (hdr == tcfr_pkg::HDR_LONG);
                mirror_rd = 32'(pos + hdr + len);
            end
            else
                pos++;
        end
        return r;
    endfunction

    task automatic mirror_command(input logic [1:0] op, input logic [7:0] b);
        case (op)
            tcfr_pkg::CMD_APPEND:
            begin
                if (mirror_fill < STORE_DEPTH)
                begin
                    mirror_bytes[mirror_fill] = b;
                    mirror_fill++;
                end
                else
                    mirror_ovf = 1'b1;
            end
            tcfr_pkg::CMD_FETCH:
                chunks_expected.push_back(scan_next_chunk());
            tcfr_pkg::CMD_CLEAR:
            begin
                mirror_fill = 0;
                mirror_rd = 32'(mirror_start);
                mirror_ovf = 1'b0;
            end
            default:
            begin
            end
        endcase
    endtask

    function automatic int draw_wait();
        return steady_flow ? 0 : int'($urandom_range(0, 19));
    endfunction

    task automatic queue_item(input logic [1:0] op, input logic [7:0] b);
        command_item_t it;
        it.op = op;
        it.value = b;
        cmd_backlog.push_back(it);
        queued_items++;
    endtask

    task automatic queue_chunk(input logic [7:0] id, input logic [31:0] len,
                               input bit ext, input int body);
        int i;
        queue_item(tcfr_pkg::CMD_APPEND, id);
        if (ext)
        begin
            queue_item(tcfr_pkg::CMD_APPEND, tcfr_pkg::LEN_ESCAPE);
            for (i = 0; i < 4; i++)
                queue_item(tcfr_pkg::CMD_APPEND, len[8*i +: 8]);
        end
        else
            queue_item(tcfr_pkg::CMD_APPEND, len[7:0]);
        for (i = 0; i < body; i++)
            queue_item(tcfr_pkg::CMD_APPEND, 8'($urandom_range(0, 255)));
    endtask

    // Fill the store up to about the start offset, sometimes a little short so
    // the first scan begins inside a chunk and has to resync.
    task automatic queue_clear_and_pad();
        int pad;
        int i;
        queue_item(tcfr_pkg::CMD_CLEAR, 8'($urandom_range(0, 255)));
        pad = int'(phase_start)
            - int'($urandom_range(0, (phase_start < 3) ? phase_start : 3));
        for (i = 0; i < pad; i++)
            queue_item(tcfr_pkg::CMD_APPEND, 8'($urandom_range(0, 255)));
    endtask

    function automatic logic [7:0] pick_pinned_id();
        case ($urandom_range(0, 5))
            0:       return 8'h08;
            1:       return 8'h0B;
            2:       return 8'h0E;
            3:       return 8'h14;
            4:       return 8'h17;
            default: return ($urandom_range(0, 3) == 0) ? 8'h16 : 8'h17;
        endcase
    endfunction

    task automatic queue_random_phase(input int target);
        int         kind;
        int         first;
        int         i;
        logic [7:0] id;
        logic [31:0] len;
        bit [8:0]   pin;
        queue_clear_and_pad();
        first = queued_items;
        while (queued_items - first < target)
        begin
            kind = int'($urandom_range(0, 99));
            if (kind < 55)
            begin
                id = ($urandom_range(0, 2) == 0) ? pick_pinned_id()
                                                 : 8'($urandom_range(0, 255));
                pin = pinned_length(id);
                if (pin[8])
                    len = 32'(pin[7:0]);
                else if ($urandom_range(0, 49) == 0)
                    len = $urandom_range(255, 300);
                else
                    len = $urandom_range(0, 12);
                queue_chunk(id, len, len >= tcfr_pkg::LEN_ESCAPE || $urandom_range(0, 4) == 0,
                            int'(len));
                if ($urandom_range(0, 1) == 0)
                    queue_item(tcfr_pkg::CMD_FETCH, 8'($urandom_range(0, 255)));
            end
            else if (kind < 65)
            begin
                // Known id carrying the wrong length.
                id = pick_pinned_id();
                pin = pinned_length(id);
                len = 32'(pin[7:0]) + $urandom_range(1, 3);
                queue_chunk(id, len, $urandom_range(0, 3) == 0, int'(len));
            end
            else if (kind < 75)
            begin
                for (i = int'($urandom_range(1, 4)); i > 0; i--)
                    queue_item(tcfr_pkg::CMD_APPEND, 8'($urandom_range(0, 255)));
            end
            else if (kind < 85)
                queue_item(tcfr_pkg::CMD_FETCH, 8'($urandom_range(0, 255)));
            else if (kind < 90)
            begin
                // Header whose value is cut short, at least for now.
                id = 8'($urandom_range(0, 255));
                pin = pinned_length(id);
                len = pin[8] ? 32'(pin[7:0]) : $urandom_range(20, 60);
                queue_chunk(id, len, $urandom_range(0, 1) == 1, int'($urandom_range(0, 5)));
            end
            else if (kind < 94)
                queue_chunk(8'($urandom_range(0, 255)), $urandom | 32'h8000_0000, 1'b1, 0);
            else if (kind < 96)
                queue_item(CMD_UNUSED, 8'($urandom_range(0, 255)));
            else
                queue_clear_and_pad();
        end
        queue_item(tcfr_pkg::CMD_FETCH, 8'($urandom_range(0, 255)));
        queue_item(tcfr_pkg::CMD_FETCH, 8'($urandom_range(0, 255)));
    endtask

    task automatic write_start_offset(input logic [7:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        mirror_start = v;
        @(negedge clk);
    endtask

    task automatic settle();
        while (cmd_backlog.size() != 0 || cmd.valid || chunks_expected.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic compare_field(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
            error_count++;
        end
    endtask

    // Command driver: the wait drawn for an item is spent after it is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd.valid <= 1'b0;
            cmd.command <= tcfr_pkg::CMD_APPEND;
            cmd.data_byte <= 8'd0;
            hold_off <= 0;
        end
        else
        begin
            if (cmd.valid && cmd.ready)
            begin
                mirror_command(cmd.command, cmd.data_byte);
                items_taken++;
            end
            if (!cmd.valid || cmd.ready)
            begin
                if (hold_off != 0)
                begin
                    cmd.valid <= 1'b0;
                    hold_off <= hold_off - 1;
                end
                else if (cmd_backlog.size() != 0)
                begin
                    next_item = cmd_backlog.pop_front();
                    cmd.valid <= 1'b1;
                    cmd.command <= next_item.op;
                    cmd.data_byte <= next_item.value;
                    hold_off <= draw_wait();
                end
                else
                    cmd.valid <= 1'b0;
            end
        end
    end

    // Result monitor: the stall drawn after a result runs only while the next
    // one is offered.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res.ready <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (res.valid && res.ready)
            begin
                if (chunks_expected.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got found=%0d id=0x%0h",
                             $time, res.found, res.tlv_id);
                    error_count++;
                end
                else
                begin
                    oldest_chunk = chunks_expected.pop_front();
                    compare_field("found", 32'(oldest_chunk.found), 32'(res.found));
                    compare_field("tlv_id", 32'(oldest_chunk.tlv_id), 32'(res.tlv_id));
                    compare_field("value_offset", 32'(oldest_chunk.value_offset),
                                  32'(res.value_offset));
                    compare_field("value_length", oldest_chunk.value_length,
                                  res.value_length);
                    compare_field("extended_header", 32'(oldest_chunk.extended_header),
                                  32'(res.extended_header));
                    compare_field("overflowed", 32'(oldest_chunk.overflowed),
                                  32'(res.overflowed));
                    chunks_checked++;
                    if (oldest_chunk.found)
                        chunks_found++;
                    if (oldest_chunk.extended_header)
                        chunks_extended++;
                end
                stall_left <= draw_wait();
                res.ready <= 1'b0;
            end
            else if (stall_left != 0)
            begin
                if (res.valid)
                begin
                    stall_left <= stall_left - 1;
                    res.ready <= (stall_left == 1);
                end
            end
            else
                res.ready <= 1'b1;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((cmd.valid && cmd.ready) || (res.valid && res.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        logic [7:0] phase_offsets [8];
        int         k;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 8'd0;
        mirror_start = tcfr_pkg::START_OFFSET_RST;
        steady_flow = 1'b0;
        phase_start = tcfr_pkg::START_OFFSET_RST;
        queued_items = 0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Out of reset the read position lies past an empty store.
        queue_item(tcfr_pkg::CMD_FETCH, 8'h00);
        settle();

        write_start_offset(8'd0);
        phase_start = 8'd0;
        queue_item(tcfr_pkg::CMD_CLEAR, 8'h00);
        queue_item(tcfr_pkg::CMD_FETCH, 8'hFF);
        queue_item(CMD_UNUSED, 8'hFF);
        // Known id with a wrong length, then candidates that overrun the fill.
        queue_item(tcfr_pkg::CMD_APPEND, 8'h0B);
        queue_item(tcfr_pkg::CMD_APPEND, 8'h01);
        queue_item(tcfr_pkg::CMD_APPEND, 8'hAA);
        queue_item(tcfr_pkg::CMD_APPEND, 8'h55);
        queue_item(tcfr_pkg::CMD_FETCH, 8'h00);
        // One more byte turns the tail into a zero-length chunk.
        queue_item(tcfr_pkg::CMD_APPEND, 8'h00);
        queue_item(tcfr_pkg::CMD_FETCH, 8'h00);
        queue_chunk(8'hFF, 32'd2, 1'b1, 2);
        queue_item(tcfr_pkg::CMD_FETCH, 8'h00);
        // The largest extended length must not wrap in the bounds test.
        queue_chunk(8'h01, 32'hFFFF_FFFF, 1'b1, 0);
        queue_item(tcfr_pkg::CMD_FETCH, 8'h00);
        queue_item(tcfr_pkg::CMD_CLEAR, 8'hFF);
        settle();

        phase_offsets[0] = 8'd255;
        phase_offsets[1] = 8'd8;
        phase_offsets[2] = 8'd0;
        phase_offsets[3] = 8'($urandom_range(0, 31));
        phase_offsets[4] = 8'd1;
        phase_offsets[5] = 8'($urandom_range(0, 255));
        phase_offsets[6] = 8'd40;
        phase_offsets[7] = 8'($urandom_range(0, 31));
        for (k = 0; k < 8; k++)
        begin
            write_start_offset(phase_offsets[k]);
            phase_start = phase_offsets[k];
            steady_flow = (k == 3);
            queue_random_phase(140);
            settle();
        end

        $display("Took %0d commands and checked %0d fetch results (%0d found, %0d extended).",
                 items_taken, chunks_checked, chunks_found, chunks_extended);
        $display("Start offsets 0 to 255, resync over bad headers and rewinds exercised; %0d mismatches.",
                 error_count);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
